FILE: design/hmf_pkg.sv
// ----------------------------------------------------------------------------
// hmf_pkg: shared constants and helpers for the histogram median filter
// Holds the frame limits, window geometry, register indexes and the
// threshold function used by the control and selection logic.
// ----------------------------------------------------------------------------
`default_nettype none
package hmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 7;
  localparam int LINES      = 2 * MAX_RADIUS;
  localparam int SIDE       = 2 * MAX_RADIUS + 1;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int RAD_W      = 3;
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int LINE_BITS  = LINES * PIX_W;
  localparam int COLM_BITS  = SIDE * PIX_W;
  localparam int SIDX_W     = 4;
  localparam int CNT_W      = 8;
  localparam int THR_W      = 7;

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Control from the frame sequencer to the selection unit.
  typedef struct packed {
    logic shift;  // push a new pixel column into the window
    logic start;  // begin a median search over the window
  } hmf_sel_ctrl_t;

  // Rank of the median inside the window: floor(side*side/2).
  function automatic logic [THR_W-1:0] thr_of(input logic [RAD_W-1:0] r);
    logic [SIDX_W-1:0] side;
    logic [7:0]        sq;
    side = {r, 1'b1};
    sq   = 8'(side) * 8'(side);
    return sq[7:1];
  endfunction

endpackage
`default_nettype wire

FILE: design/hmf_line_buf.sv
// ----------------------------------------------------------------------------
// hmf_line_buf: line store for the median filter
// One word per column holds the last rows of that column. A read-modify-write
// shifts the new pixel in and hands the whole pixel column to the window.
// ----------------------------------------------------------------------------
`default_nettype none
module hmf_line_buf (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [hmf_pkg::COL_W-1:0]     rd_addr,
  input  wire logic                          wr_en,
  input  wire logic [hmf_pkg::COL_W-1:0]     wr_addr,
  input  wire logic [hmf_pkg::PIX_W-1:0]     px,
  output logic      [hmf_pkg::COLM_BITS-1:0] column
);

  logic [hmf_pkg::LINE_BITS-1:0] mem [hmf_pkg::MAX_WIDTH];
  logic [hmf_pkg::LINE_BITS-1:0] rd_r;

  // Registered read of the stored rows at this column.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Write back with every row moved down by one and the new pixel on top.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {rd_r[hmf_pkg::LINE_BITS-hmf_pkg::PIX_W-1:0], px};
    end
  end

  // Row k of the column sits at bits [8k +: 8]; row 0 is the current row.
  assign column = {rd_r, px};

endmodule
`default_nettype wire

FILE: design/hmf_select.sv
// ----------------------------------------------------------------------------
// hmf_select: column window and bit-serial median search
// Keeps the last pixel columns and finds the median one result bit at a time,
// most significant first, counting one window column per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module hmf_select (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hmf_pkg::hmf_sel_ctrl_t        ctrl,
  input  wire logic [hmf_pkg::COLM_BITS-1:0] col_in,
  input  wire logic [hmf_pkg::RAD_W-1:0]     radius,
  output logic                               done,
  output logic      [hmf_pkg::PIX_W-1:0]     median
);

  localparam int LAST_COL = hmf_pkg::SIDE - 1;

  logic [hmf_pkg::COLM_BITS-1:0] win_r [hmf_pkg::SIDE];

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [2:0]                  bit_r, bit_nxt;
  logic [hmf_pkg::SIDX_W-1:0]  cidx_r, cidx_nxt;
  logic [hmf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [hmf_pkg::THR_W-1:0]   rank_r, rank_nxt;
  logic [hmf_pkg::PIX_W-1:0]   pref_r, pref_nxt;

  logic [hmf_pkg::SIDX_W-1:0]  side;
  logic [hmf_pkg::SIDX_W-1:0]  first_col;
  logic [hmf_pkg::COLM_BITS-1:0] cur_col;
  logic [hmf_pkg::PIX_W-1:0]   hi_mask;
  logic [hmf_pkg::SIDX_W-1:0]  pop;
  logic [hmf_pkg::CNT_W-1:0]   sum;

  assign side      = {radius, 1'b1};
  assign first_col = hmf_pkg::SIDX_W'(hmf_pkg::SIDE) - side;

  // Window of pixel columns; the newest column enters at the top.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int j = 0; j < hmf_pkg::SIDE - 1; j++) begin
        win_r[j] <= win_r[j+1];
      end
      win_r[hmf_pkg::SIDE-1] <= col_in;
    end
  end

  // Count pixels in this column whose upper bits match the prefix with a zero here.
  always_comb begin
    cur_col = win_r[cidx_r];
    hi_mask = 8'hFF << bit_r;
    pop     = '0;
    for (int k = 0; k < hmf_pkg::SIDE; k++) begin
      if ((hmf_pkg::SIDX_W'(k) < side) &&
          (((cur_col[k*hmf_pkg::PIX_W +: hmf_pkg::PIX_W] ^ pref_r) & hi_mask) == '0)) begin
        pop = pop + 1'b1;
      end
    end
    sum = cnt_r + hmf_pkg::CNT_W'(pop);
  end

  // Search sequencer: one column per cycle, one result bit per sweep.
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    cidx_nxt = cidx_r;
    cnt_nxt  = cnt_r;
    rank_nxt = rank_r;
    pref_nxt = pref_r;
    if (ctrl.start) begin
      run_nxt  = 1'b1;
      bit_nxt  = 3'd7;
      cidx_nxt = first_col;
      cnt_nxt  = '0;
      rank_nxt = hmf_pkg::thr_of(radius);
      pref_nxt = '0;
    end else if (run_r) begin
      if (cidx_r == hmf_pkg::SIDX_W'(LAST_COL)) begin
        if ({1'b0, rank_r} >= sum) begin
          pref_nxt[bit_r] = 1'b1;
          rank_nxt        = rank_r - hmf_pkg::THR_W'(sum);
        end
        cidx_nxt = first_col;
        cnt_nxt  = '0;
        if (bit_r == 3'd0) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end else begin
          bit_nxt = bit_r - 3'd1;
        end
      end else begin
        cidx_nxt = cidx_r + 1'b1;
        cnt_nxt  = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r  <= bit_nxt;
    cidx_r <= cidx_nxt;
    cnt_r  <= cnt_nxt;
    rank_r <= rank_nxt;
    pref_r <= pref_nxt;
  end

  assign done   = done_r;
  assign median = pref_r;

endmodule
`default_nettype wire

FILE: design/histogram_median_filter_core.sv
// ----------------------------------------------------------------------------
// histogram_median_filter_core: streaming 2-D median filter, 8-bit pixels
// Filters a raster-order frame with a square window of radius 0 to 7.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_* one transaction each, in raster order. For each
//   pixel that completes a window lying wholly inside the frame, one result
//   leaves on out_*: the window median with the column and row of the window
//   center; out_tlast marks the result for the last pixel of the frame.
//   Border pixels give no result.
//   A pixel with no result passes the input and update states only. A pixel
//   with a result also waits for the median search, which counts one window
//   column per cycle for each of the 8 result bits.
//   A new pixel is accepted while the previous result still waits in the
//   output register; when the receiver stalls, the next result waits inside
//   the block and input stops until the output register frees.
//   Reset sets r=1, width 640, height 480 and starts a new frame. A write on
//   cfg_* also restarts the frame; write only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module histogram_median_filter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input pixel channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] pixel_in
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] median_value, [17:8] out_col,
                                       // [29:18] out_row, [31:30] zero
  output logic             out_tlast,  // frame_last
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [12:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_SEL    = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [hmf_pkg::RAD_W-1:0] rad_r;
  logic [hmf_pkg::WID_W-1:0] wid_r;
  logic [hmf_pkg::HGT_W-1:0] hgt_r;
  logic [hmf_pkg::COL_W-1:0] col_r, col_nxt;
  logic [hmf_pkg::ROW_W-1:0] row_r, row_nxt;

  logic [hmf_pkg::COL_W-1:0] c_cur_r;
  logic [hmf_pkg::PIX_W-1:0] px_r;
  logic                      emit_r;
  logic [hmf_pkg::COL_W-1:0] res_col_r;
  logic [hmf_pkg::ROW_W-1:0] res_row_r;
  logic                      res_last_r;

  logic                      out_valid_r;
  logic [hmf_pkg::PIX_W-1:0] out_med_r;
  logic [hmf_pkg::COL_W-1:0] out_col_r;
  logic [hmf_pkg::ROW_W-1:0] out_row_r;
  logic                      out_last_r;

  logic [hmf_pkg::WID_W-1:0] eff_w;
  logic [hmf_pkg::HGT_W-1:0] eff_h;
  logic [hmf_pkg::COL_W-1:0] c_n;
  logic [hmf_pkg::ROW_W-1:0] r_n;
  logic [hmf_pkg::SIDX_W-1:0] two_r;
  logic                      accept;
  logic                      load_out;
  logic                      cfg_hit;

  hmf_pkg::hmf_sel_ctrl_t          sel_ctrl;
  logic [hmf_pkg::COLM_BITS-1:0]   column;
  logic                            sel_done;
  logic [hmf_pkg::PIX_W-1:0]       sel_median;

  // Effective frame size, held inside the supported range.
  always_comb begin
    if (wid_r == '0) begin
      eff_w = hmf_pkg::WID_W'(1);
    end else if (wid_r > hmf_pkg::WID_W'(hmf_pkg::MAX_WIDTH)) begin
      eff_w = hmf_pkg::WID_W'(hmf_pkg::MAX_WIDTH);
    end else begin
      eff_w = wid_r;
    end
    if (hgt_r == '0) begin
      eff_h = hmf_pkg::HGT_W'(1);
    end else if (hgt_r > hmf_pkg::HGT_W'(hmf_pkg::MAX_HEIGHT)) begin
      eff_h = hmf_pkg::HGT_W'(hmf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = hgt_r;
    end
  end

  // Only a write to an existing register restarts the frame.
  assign cfg_hit = cfg_we && ((cfg_addr == hmf_pkg::REG_RADIUS) ||
                              (cfg_addr == hmf_pkg::REG_WIDTH) ||
                              (cfg_addr == hmf_pkg::REG_HEIGHT));

  // Position of the pixel on the input and the next position.
  always_comb begin
    c_n   = ({1'b0, col_r} >= eff_w) ? '0 : col_r;
    r_n   = ({1'b0, row_r} >= eff_h) ? '0 : row_r;
    two_r = {rad_r, 1'b0};
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if ({1'b0, c_n} + 1'b1 >= eff_w) begin
        col_nxt = '0;
        row_nxt = ({1'b0, r_n} + 1'b1 >= eff_h) ? '0 : r_n + 1'b1;
      end else begin
        col_nxt = c_n + 1'b1;
      end
    end
  end

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign load_out = (state_r == S_HOLD) && (!out_valid_r || out_tready);

  // Frame sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = emit_r ? S_SEL : S_IDLE;
      S_SEL:    if (sel_done) state_nxt = S_HOLD;
      S_HOLD:   if (load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign sel_ctrl.shift = (state_r == S_UPDATE);
  assign sel_ctrl.start = (state_r == S_UPDATE) && emit_r;

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rad_r       <= hmf_pkg::RAD_W'(1);
      wid_r       <= hmf_pkg::WID_W'(640);
      hgt_r       <= hmf_pkg::HGT_W'(480);
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          hmf_pkg::REG_RADIUS: rad_r <= cfg_wdata[hmf_pkg::RAD_W-1:0];
          hmf_pkg::REG_WIDTH:  wid_r <= cfg_wdata[hmf_pkg::WID_W-1:0];
          hmf_pkg::REG_HEIGHT: hgt_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-pixel payload captured at the input transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      c_cur_r    <= c_n;
      px_r       <= in_tdata;
      emit_r     <= ({6'd0, two_r} <= c_n) && ({8'd0, two_r} <= r_n);
      res_col_r  <= c_n - hmf_pkg::COL_W'(rad_r);
      res_row_r  <= r_n - hmf_pkg::ROW_W'(rad_r);
      res_last_r <= ({1'b0, c_n} == eff_w - 1'b1) && ({1'b0, r_n} == eff_h - 1'b1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_med_r  <= sel_median;
      out_col_r  <= res_col_r;
      out_row_r  <= res_row_r;
      out_last_r <= res_last_r;
    end
  end

  hmf_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c_n),
    .wr_en   (state_r == S_UPDATE),
    .wr_addr (c_cur_r),
    .px      (px_r),
    .column  (column)
  );

  hmf_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (sel_ctrl),
    .col_in (column),
    .radius (rad_r),
    .done   (sel_done),
    .median (sel_median)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_row_r, out_col_r, out_med_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
